### design/dple_pkg.sv
package dple_pkg;

	// Sequencer phases of one exchange.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAKE,
		PH_GUARD_A,
		PH_QUARTER,
		PH_GUARD_B
	} phase_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CLOCK_PERIOD = 2'd0;
	localparam logic [1:0] CFG_WAKE         = 2'd1;
	localparam logic [1:0] CFG_GUARD        = 2'd2;

	// Register reset values.
	localparam logic [15:0] CLOCK_PERIOD_RESET = 16'd10;
	localparam logic [15:0] WAKE_RESET         = 16'd100;
	localparam logic [15:0] GUARD_RESET        = 16'd1;

	// Wake, first guard, four quarters and the closing guard can all end on one beat.
	localparam int MAX_ACTIONS = 7;
	localparam logic [1:0] LAST_QUARTER = 2'd3;

	typedef struct packed {
		logic [15:0] clock_period;
		logic [15:0] wake;
		logic [15:0] guard;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] countdown;
		logic [1:0]  quarter;
		logic [7:0]  send;
		logic [7:0]  recv;
		logic        tx_latch;
		logic        tx_en;
		logic        wake;
		logic        clk0;
		logic        clk1;
		logic        d0;
		logic        d1;
		logic        done;
	} link_state_t;

	typedef struct packed {
		logic       tx_enable;
		logic       wake_line;
		logic       clock_low;
		logic       clock_high;
		logic       data_bit0;
		logic       data_bit1;
		logic       busy;
		logic       done;
		logic [7:0] received_byte;
	} result_t;

	// One action of an ended wait.
	function automatic link_state_t run_action(input link_state_t st, input cfg_t cfg,
			input logic pe, input logic b0, input logic b1);
		link_state_t ns;
		logic [1:0]  nq;
		ns = st;
		nq = st.quarter + 2'd1;
		case (st.phase)
			PH_WAKE, PH_GUARD_A: begin
				if (st.phase == PH_WAKE && !st.tx_latch) begin
					ns.countdown = cfg.guard;
					ns.phase     = PH_GUARD_A;
				end else begin
					if (st.phase == PH_GUARD_A) begin
						ns.tx_en = 1'b0;
					end
					ns.clk0      = 1'b0;
					ns.clk1      = 1'b0;
					ns.quarter   = 2'd0;
					ns.d0        = st.send[0];
					ns.d1        = st.send[1];
					ns.countdown = cfg.clock_period;
					ns.phase     = PH_QUARTER;
				end
			end
			PH_QUARTER: begin
				if (pe) begin
					ns.recv[{st.quarter, 1'b0}] = st.recv[{st.quarter, 1'b0}] | b0;
					ns.recv[{st.quarter, 1'b1}] = st.recv[{st.quarter, 1'b1}] | b1;
				end
				// Two-bit count 00, 01, 10, 11 on the clock pins.
				if (st.clk0) begin
					ns.clk1 = ~st.clk1;
				end
				ns.clk0 = ~st.clk0;
				if (st.quarter == LAST_QUARTER) begin
					ns.tx_en     = 1'b0;
					ns.countdown = cfg.guard;
					ns.phase     = PH_GUARD_B;
				end else begin
					ns.quarter   = nq;
					ns.d0        = st.send[{nq, 1'b0}];
					ns.d1        = st.send[{nq, 1'b1}];
					ns.countdown = cfg.clock_period;
				end
			end
			PH_GUARD_B: begin
				ns.clk1  = 1'b1;
				ns.clk0  = 1'b0;
				ns.phase = PH_IDLE;
				ns.done  = 1'b1;
			end
			default: begin
				ns = st;
			end
		endcase
		return ns;
	endfunction

endpackage

### design/dibit_parallel_link_exchange.sv
// The result of an accepted beat is registered into the output register, or into the skid entry
// while an untaken result holds it. Throughput: one beat per cycle while the skid entry is empty;
// all chained wait actions resolve in one pass. A two-entry result buffer lets input beats be
// taken while a result waits. Reset (arst_n low, asynchronous): sequencer idle, its pin levels
// low but the clock parked at 10, registers at 10, 100 and 1 ticks, result buffer empty.
module dibit_parallel_link_exchange
	import dple_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  send_byte,
	input  logic        transmit,
	input  logic        partner_enable,
	input  logic        partner_bit0,
	input  logic        partner_bit1,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_enable,
	output logic        wake_line,
	output logic        clock_low,
	output logic        clock_high,
	output logic        data_bit0,
	output logic        data_bit1,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  received_byte
);

	cfg_t        cfg_q;
	link_state_t st_q;
	link_state_t st_nxt;
	result_t     res_nxt;
	result_t     res_q;
	result_t     skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;
	logic        accept;
	logic        take;

	assign in_ready = ~skid_valid_q;
	assign accept   = in_valid & in_ready;
	assign take     = out_valid_q & out_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_period <= CLOCK_PERIOD_RESET;
			cfg_q.wake         <= WAKE_RESET;
			cfg_q.guard        <= GUARD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLOCK_PERIOD: cfg_q.clock_period <= cfg_data;
				CFG_WAKE:         cfg_q.wake         <= cfg_data;
				CFG_GUARD:        cfg_q.guard        <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	// Next state: the start or tick, then every wait that has ended.
	always_comb begin
		st_nxt      = st_q;
		st_nxt.done = 1'b0;
		if (command) begin
			if (st_q.phase == PH_IDLE) begin
				st_nxt.send      = send_byte;
				st_nxt.tx_latch  = transmit;
				st_nxt.recv      = 8'd0;
				st_nxt.quarter   = 2'd0;
				st_nxt.tx_en     = 1'b1;
				st_nxt.wake      = 1'b1;
				st_nxt.countdown = cfg_q.wake;
				st_nxt.phase     = PH_WAKE;
			end
		end else if (st_q.phase != PH_IDLE && st_q.countdown != 16'd0) begin
			st_nxt.countdown = st_q.countdown - 16'd1;
		end
		for (int i = 0; i < MAX_ACTIONS; i++) begin
			if (st_nxt.phase != PH_IDLE && st_nxt.countdown == 16'd0) begin
				st_nxt = run_action(st_nxt, cfg_q, partner_enable, partner_bit0, partner_bit1);
			end
		end
	end

	// Result of the beat, taken from the next state.
	always_comb begin
		res_nxt.tx_enable     = st_nxt.tx_en;
		res_nxt.wake_line     = st_nxt.wake;
		res_nxt.clock_low     = st_nxt.clk0;
		res_nxt.clock_high    = st_nxt.clk1;
		res_nxt.data_bit0     = st_nxt.d0;
		res_nxt.data_bit1     = st_nxt.d1;
		res_nxt.busy          = (st_nxt.phase != PH_IDLE);
		res_nxt.done          = st_nxt.done;
		res_nxt.received_byte = st_nxt.done ? st_nxt.recv : 8'd0;
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase     <= PH_IDLE;
			st_q.countdown <= 16'd0;
			st_q.quarter   <= 2'd0;
			st_q.send      <= 8'd0;
			st_q.recv      <= 8'd0;
			st_q.tx_latch  <= 1'b0;
			st_q.tx_en     <= 1'b0;
			st_q.wake      <= 1'b0;
			st_q.clk0      <= 1'b0;
			st_q.clk1      <= 1'b1;
			st_q.d0        <= 1'b0;
			st_q.d1        <= 1'b0;
			st_q.done      <= 1'b0;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	// Result buffer control: output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result buffer payload.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				res_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !take) begin
				skid_q <= res_nxt;
			end else begin
				res_q <= res_nxt;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign tx_enable     = res_q.tx_enable;
	assign wake_line     = res_q.wake_line;
	assign clock_low     = res_q.clock_low;
	assign clock_high    = res_q.clock_high;
	assign data_bit0     = res_q.data_bit0;
	assign data_bit1     = res_q.data_bit1;
	assign busy_res      = res_q.busy;
	assign done_res      = res_q.done;
	assign received_byte = res_q.received_byte;

	// The skid entry is only ever filled behind a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	// Once raised, the wake line never drops.
	assert property (@(posedge clk) disable iff (!arst_n) st_q.wake |=> st_q.wake)
		else $error("wake line dropped after being raised");

	// A completed exchange leaves the sequencer idle with the clock parked at 10.
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.done |-> (st_q.phase == PH_IDLE && st_q.clk1 && !st_q.clk0))
		else $error("exchange reported done without returning to idle");

	// A start taken while idle leaves transmit enable or a later phase in effect.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command && st_q.phase == PH_IDLE) |=> (st_q.wake && (st_q.tx_en ||
		st_q.phase == PH_QUARTER || st_q.phase == PH_GUARD_B || st_q.done)))
		else $error("start beat did not begin an exchange");

	// A reported byte is only nonzero on the done beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.done) |-> (res_q.received_byte == 8'd0))
		else $error("received byte shown without done");

endmodule

### verif/tb_dibit_parallel_link_exchange.sv
`timescale 1ns / 1ps

module tb_dibit_parallel_link_exchange
	import dple_pkg::*;
();

	// Command codes carried by one input beat.
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Register index that decodes to nothing.
	localparam logic [1:0] CFG_SPARE = 2'd3;

	localparam int MAX_IDLE      = 18;
	localparam int LONG_HOLD     = 60;
	localparam int HOLD_FIRST    = 600;
	localparam int HOLD_SECOND   = 1200;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_BEATS   = 240;
	localparam int TIMEOUT_NS    = 10_000_000;

	typedef struct packed {
		logic       cmd;
		logic [7:0] payload;
		logic       tx;
		logic       pe;
		logic       b0;
		logic       b1;
	} link_item_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        cfg_we         = 1'b0;
	logic [1:0]  cfg_index      = 2'd0;
	logic [15:0] cfg_data       = 16'd0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic        command        = CMD_TICK;
	logic [7:0]  send_byte      = 8'd0;
	logic        transmit       = 1'b0;
	logic        partner_enable = 1'b0;
	logic        partner_bit0   = 1'b0;
	logic        partner_bit1   = 1'b0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic        tx_enable;
	logic        wake_line;
	logic        clock_low;
	logic        clock_high;
	logic        data_bit0;
	logic        data_bit1;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  received_byte;

	dibit_parallel_link_exchange dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.send_byte      (send_byte),
		.transmit       (transmit),
		.partner_enable (partner_enable),
		.partner_bit0   (partner_bit0),
		.partner_bit1   (partner_bit1),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.tx_enable      (tx_enable),
		.wake_line      (wake_line),
		.clock_low      (clock_low),
		.clock_high     (clock_high),
		.data_bit0      (data_bit0),
		.data_bit1      (data_bit1),
		.busy_res       (busy_res),
		.done_res       (done_res),
		.received_byte  (received_byte)
	);

	always #10 clk = ~clk;

	link_item_t pending_beats[$];
	result_t    expected_pins[$];
	link_item_t next_beat;
	result_t    want;
	int         mismatches     = 0;
	int         results_seen   = 0;
	int         gap_left       = 0;
	int         stall_left     = 0;
	int         hold_left      = 0;
	logic       sender_idles   = 1'b1;
	logic       receiver_idles = 1'b1;

	// Predicted register contents and sequencer state.
	logic [15:0] period_q   = CLOCK_PERIOD_RESET;
	logic [15:0] wake_q     = WAKE_RESET;
	logic [15:0] guard_q    = GUARD_RESET;
	phase_t      seq_phase  = PH_IDLE;
	logic [15:0] wait_left  = 16'd0;
	logic [1:0]  quarter    = 2'd0;
	logic [7:0]  send_q     = 8'd0;
	logic [7:0]  recv_q     = 8'd0;
	logic        tx_latch_q = 1'b0;
	logic        pin_txen   = 1'b0;
	logic        pin_wake   = 1'b0;
	logic        pin_clk0   = 1'b0;
	logic        pin_clk1   = 1'b1;
	logic        pin_d0     = 1'b0;
	logic        pin_d1     = 1'b0;

	// Put the current quarter's two bits on the data lines and start its wait.
	function automatic void load_dibit();
		logic [7:0] shifted;
		shifted   = send_q >> {quarter, 1'b0};
		pin_d0    = shifted[0];
		pin_d1    = shifted[1];
		wait_left = period_q;
		seq_phase = PH_QUARTER;
	endfunction

	function automatic void open_quarters();
		pin_clk0 = 1'b0;
		pin_clk1 = 1'b0;
		quarter  = 2'd0;
		load_dibit();
	endfunction

	// Carry out every wait that has run out; true when the exchange finishes.
	function automatic logic run_ended_waits(input logic pe, input logic b0, input logic b1);
		logic finished;
		finished = 1'b0;
		while (seq_phase != PH_IDLE && wait_left == 16'd0) begin
			case (seq_phase)
				PH_WAKE: begin
					if (tx_latch_q) begin
						open_quarters();
					end else begin
						wait_left = guard_q;
						seq_phase = PH_GUARD_A;
					end
				end
				PH_GUARD_A: begin
					pin_txen = 1'b0;
					open_quarters();
				end
				PH_QUARTER: begin
					if (pe) begin
						recv_q = recv_q | ({6'd0, b1, b0} << {quarter, 1'b0});
					end
					// The clock pins count 00, 01, 10, 11 across the quarters.
					if (pin_clk0) begin
						pin_clk1 = ~pin_clk1;
					end
					pin_clk0 = ~pin_clk0;
					if (quarter == LAST_QUARTER) begin
						pin_txen  = 1'b0;
						wait_left = guard_q;
						seq_phase = PH_GUARD_B;
					end else begin
						quarter = quarter + 2'd1;
						load_dibit();
					end
				end
				PH_GUARD_B: begin
					pin_clk1  = 1'b1;
					pin_clk0  = 1'b0;
					seq_phase = PH_IDLE;
					finished  = 1'b1;
				end
				default: begin
					seq_phase = PH_IDLE;
				end
			endcase
		end
		return finished;
	endfunction

	// Advance the predicted link by one accepted beat and return the pin levels.
	function automatic result_t link_step(input logic cmd, input logic [7:0] tx_byte,
			input logic tx, input logic pe, input logic b0, input logic b1);
		result_t r;
		logic    fin;
		fin = 1'b0;
		if (cmd == CMD_START) begin
			// A start during an exchange is dropped.
			if (seq_phase == PH_IDLE) begin
				send_q     = tx_byte;
				tx_latch_q = tx;
				recv_q     = 8'd0;
				quarter    = 2'd0;
				pin_txen   = 1'b1;
				pin_wake   = 1'b1;
				wait_left  = wake_q;
				seq_phase  = PH_WAKE;
				fin        = run_ended_waits(pe, b0, b1);
			end
		end else if (seq_phase != PH_IDLE) begin
			if (wait_left != 16'd0) begin
				wait_left = wait_left - 16'd1;
			end
			fin = run_ended_waits(pe, b0, b1);
		end
		r.tx_enable     = pin_txen;
		r.wake_line     = pin_wake;
		r.clock_low     = pin_clk0;
		r.clock_high    = pin_clk1;
		r.data_bit0     = pin_d0;
		r.data_bit1     = pin_d1;
		r.busy          = (seq_phase != PH_IDLE);
		r.done          = fin;
		r.received_byte = fin ? recv_q : 8'd0;
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
			mismatches++;
		end
	endfunction

	function automatic link_item_t random_beat(input int start_pct);
		link_item_t b;
		b.cmd     = ($urandom_range(0, 99) < start_pct) ? CMD_START : CMD_TICK;
		b.payload = 8'($urandom_range(0, 255));
		b.tx      = 1'($urandom_range(0, 1));
		b.pe      = ($urandom_range(0, 4) != 0);
		b.b0      = 1'($urandom_range(0, 1));
		b.b1      = 1'($urandom_range(0, 1));
		return b;
	endfunction

	task automatic queue_beat(input logic cmd, input logic [7:0] payload, input logic tx,
			input logic pe, input logic b0, input logic b1);
		pending_beats.push_back('{cmd, payload, tx, pe, b0, b1});
	endtask

	// Wait until every queued beat has gone in and every result has come back.
	task automatic wait_quiet();
		do @(negedge clk);
		while (pending_beats.size() != 0 || in_valid || expected_pins.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// Tick the link until the exchange in progress has ended.
	task automatic finish_exchange();
		while (seq_phase != PH_IDLE) begin
			pending_beats.push_back(random_beat(0));
			wait_quiet();
		end
	endtask

	// Write all timing registers and the spare index while no beat is in flight.
	task automatic apply_timing(input logic [15:0] period_v, input logic [15:0] wake_v,
			input logic [15:0] guard_v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CLOCK_PERIOD;
		cfg_data  <= period_v;
		period_q  = period_v;
		@(posedge clk);
		cfg_index <= CFG_WAKE;
		cfg_data  <= wake_v;
		wake_q    = wake_v;
		@(posedge clk);
		cfg_index <= CFG_GUARD;
		cfg_data  <= guard_v;
		guard_q   = guard_v;
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data  <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Driver: offers queued beats, with a random gap drawn for each one while sender_idles is set.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_pins.push_back(link_step(command, send_byte, transmit,
					partner_enable, partner_bit0, partner_bit1));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_beats.size() != 0) begin
					next_beat = pending_beats.pop_front();
					command        <= next_beat.cmd;
					send_byte      <= next_beat.payload;
					transmit       <= next_beat.tx;
					partner_enable <= next_beat.pe;
					partner_bit0   <= next_beat.b0;
					partner_bit1   <= next_beat.b1;
					in_valid       <= 1'b1;
					gap_left = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result beat and stalls the output between beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_pins.size() == 0) begin
					$display("%0t ns: result beat with nothing expected, got received_byte %0d",
						$time, received_byte);
					mismatches++;
				end else begin
					want = expected_pins.pop_front();
					check_field("tx_enable", 8'(want.tx_enable), 8'(tx_enable));
					check_field("wake_line", 8'(want.wake_line), 8'(wake_line));
					check_field("clock_low", 8'(want.clock_low), 8'(clock_low));
					check_field("clock_high", 8'(want.clock_high), 8'(clock_high));
					check_field("data_bit0", 8'(want.data_bit0), 8'(data_bit0));
					check_field("data_bit1", 8'(want.data_bit1), 8'(data_bit1));
					check_field("busy_res", 8'(want.busy), 8'(busy_res));
					check_field("done_res", 8'(want.done), 8'(done_res));
					check_field("received_byte", want.received_byte, received_byte);
				end
				stall_left = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
				// A long hold lets the block fill and push back on the sender.
				if (results_seen == HOLD_FIRST || results_seen == HOLD_SECOND) begin
					hold_left = LONG_HOLD;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset timing: a tick while idle, a start, and a start while busy.
		queue_beat(CMD_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
		queue_beat(CMD_START, 8'h96, 1'b1, 1'b1, 1'b1, 1'b1);
		queue_beat(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
		for (int i = 0; i < 150; i++) begin
			pending_beats.push_back(random_beat(5));
		end
		wait_quiet();
		finish_exchange();

		// All waits zero: every exchange completes on its start beat.
		apply_timing(16'd0, 16'd0, 16'd0);
		queue_beat(CMD_START, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
		queue_beat(CMD_START, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1);
		queue_beat(CMD_START, 8'hA5, 1'b1, 1'b1, 1'b1, 1'b0);
		wait_quiet();

		// One tick per quarter, a two tick closing guard, partner enable dropped once.
		apply_timing(16'd1, 16'd0, 16'd2);
		queue_beat(CMD_START, 8'h3C, 1'b1, 1'b1, 1'b1, 1'b1);
		queue_beat(CMD_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
		queue_beat(CMD_START, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1);
		queue_beat(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
		queue_beat(CMD_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
		queue_beat(CMD_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
		queue_beat(CMD_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
		queue_beat(CMD_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
		queue_beat(CMD_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
		wait_quiet();

		// Random phases with short waits; writes may land in mid exchange.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			sender_idles   = (p % 3 != 1);
			receiver_idles = (p % 4 != 2);
			if (p == 0) begin
				apply_timing(16'd1, 16'd0, 16'd0);
			end else begin
				apply_timing(16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
					16'($urandom_range(0, 3)));
			end
			for (int i = 0; i < PHASE_BEATS; i++) begin
				pending_beats.push_back(random_beat(12));
			end
			wait_quiet();
		end

		// Largest waits last, since an exchange under them never ends in this run.
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		finish_exchange();
		apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_beat(CMD_START, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
		queue_beat(CMD_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
		queue_beat(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_beat(CMD_START, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b1);
		queue_beat(CMD_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
		wait_quiet();

		repeat (5) @(negedge clk);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
